// File: hw/rtl/hsdc_pkg.sv
// Package with shared types, constants and the cross-product schedule of the degeneracy check.
`timescale 1ns / 1ps
`default_nettype none
package hsdc_pkg;

  localparam int unsigned FractionBits  = 8;
  localparam int unsigned SamplePoints  = 4;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned DiffW         = CoordW + 1;
  localparam int unsigned ProdW         = 2 * DiffW;
  localparam int unsigned AccW          = ProdW + 1;
  localparam int unsigned SumW          = CoordW + 2;
  localparam int unsigned PointW        = 4 * CoordW;
  localparam int unsigned IdxW          = $clog2(SamplePoints);
  localparam int unsigned ShiftW        = 6;
  localparam int unsigned CrossCnt      = 14;
  localparam int unsigned CrossW        = $clog2(CrossCnt);
  localparam int unsigned NegW          = 3;
  localparam int unsigned OutDataW      = 8;

  localparam logic [IdxW-1:0]   LastPoint     = IdxW'(SamplePoints - 1);
  localparam logic [ShiftW-1:0] TolShiftReset = ShiftW'(23 - FractionBits);
  localparam logic [CrossW-1:0] LastCross     = CrossW'(CrossCnt - 1);

  typedef enum logic [1:0] {
    VerdictOk     = 2'd0,
    VerdictSrcCol = 2'd1,
    VerdictDstCol = 2'd2,
    VerdictOrient = 2'd3
  } verdict_e;

  typedef enum logic [3:0] {
    StIdle,
    StBase,
    StPts,
    StDiff,
    StMul1,
    StMul2,
    StAcc,
    StEval,
    StDone
  } state_e;

  // cross(pa - base, pb - base) on the source or destination set
  typedef struct packed {
    logic [IdxW-1:0] base;
    logic [IdxW-1:0] pa;
    logic [IdxW-1:0] pb;
    logic            dst;
    logic            orient;
  } cross_desc_t;

  function automatic cross_desc_t cross_desc(logic [CrossW-1:0] c);
    cross_desc_t d;
    d = '{base: 2'd3, pa: 2'd0, pb: 2'd1, dst: 1'b0, orient: 1'b0};
    case (c)
      4'd0:  d = '{base: 2'd3, pa: 2'd0, pb: 2'd1, dst: 1'b0, orient: 1'b0};
      4'd1:  d = '{base: 2'd3, pa: 2'd0, pb: 2'd2, dst: 1'b0, orient: 1'b0};
      4'd2:  d = '{base: 2'd3, pa: 2'd1, pb: 2'd2, dst: 1'b0, orient: 1'b0};
      4'd3:  d = '{base: 2'd3, pa: 2'd0, pb: 2'd1, dst: 1'b1, orient: 1'b0};
      4'd4:  d = '{base: 2'd3, pa: 2'd0, pb: 2'd2, dst: 1'b1, orient: 1'b0};
      4'd5:  d = '{base: 2'd3, pa: 2'd1, pb: 2'd2, dst: 1'b1, orient: 1'b0};
      4'd6:  d = '{base: 2'd0, pa: 2'd1, pb: 2'd2, dst: 1'b0, orient: 1'b1};
      4'd7:  d = '{base: 2'd0, pa: 2'd1, pb: 2'd2, dst: 1'b1, orient: 1'b1};
      4'd8:  d = '{base: 2'd1, pa: 2'd2, pb: 2'd3, dst: 1'b0, orient: 1'b1};
      4'd9:  d = '{base: 2'd1, pa: 2'd2, pb: 2'd3, dst: 1'b1, orient: 1'b1};
      4'd10: d = '{base: 2'd0, pa: 2'd2, pb: 2'd3, dst: 1'b0, orient: 1'b1};
      4'd11: d = '{base: 2'd0, pa: 2'd2, pb: 2'd3, dst: 1'b1, orient: 1'b1};
      4'd12: d = '{base: 2'd0, pa: 2'd1, pb: 2'd3, dst: 1'b0, orient: 1'b1};
      4'd13: d = '{base: 2'd0, pa: 2'd1, pb: 2'd3, dst: 1'b1, orient: 1'b1};
      default: d = '{base: 2'd3, pa: 2'd0, pb: 2'd1, dst: 1'b0, orient: 1'b0};
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/homography_sample_degeneracy_check_core.sv
// Four-point homography sample degeneracy check with one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
// Points 0 to 2 are stored as they are taken and give no result. Point 3 starts
// a check of fourteen exact cross products (six collinearity tests, eight
// triangle orientations), each built in the steps base, points, difference,
// two multiplies, accumulate and evaluate by one shared 33x33 multiplier and a
// two-port point memory; the input is not ready until the verdict is issued.
// A finished verdict waits in the output register while new points are taken.
// tolerance_shift resets to 15 and may be written only while the block is idle.
module homography_sample_degeneracy_check_core
  import hsdc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [ShiftW-1:0]    cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // src_x, src_y, dst_x, dst_y
  input  wire logic [PointW-1:0]    s_axis_tdata,
  // point_index
  input  wire logic [IdxW-1:0]      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // accepted, verdict_code, zero fill
  output logic [OutDataW-1:0]       m_axis_tdata
);

  state_e                   state_q, state_d;
  logic [CrossW-1:0]        cross_q, cross_d;
  logic [ShiftW-1:0]        tol_shift_q;
  logic                     src_col_q, src_col_d;
  logic                     dst_col_q, dst_col_d;
  logic                     src_nz_q, src_nz_d;
  logic                     src_neg_q, src_neg_d;
  logic [NegW-1:0]          neg_cnt_q, neg_cnt_d;
  logic                     out_valid_q, out_valid_d;
  verdict_e                 verdict_q, verdict_d;

  logic [PointW-1:0]        mem_q [SamplePoints];
  logic [PointW-1:0]        rd0_q, rd1_q, base_q;
  logic [IdxW-1:0]          raddr0, raddr1;
  logic signed [DiffW-1:0]  ax_q, ay_q, bx_q, by_q;
  logic signed [DiffW-1:0]  ax_d, ay_d, bx_d, by_d;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;
  logic [SumW-1:0]          sum_q;

  cross_desc_t              desc;
  logic                     in_acc;
  logic [SumW-1:0]          tol;
  logic signed [AccW-1:0]   tol_s;
  logic                     hit;
  logic                     acc_nz;
  logic signed [DiffW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;

  function automatic logic [CoordW-1:0] pick_x(logic [PointW-1:0] w, logic dst);
    return dst ? w[3*CoordW-1:2*CoordW] : w[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] pick_y(logic [PointW-1:0] w, logic dst);
    return dst ? w[4*CoordW-1:3*CoordW] : w[2*CoordW-1:CoordW];
  endfunction

  function automatic logic signed [DiffW-1:0] sub33(logic [CoordW-1:0] a,
                                                   logic [CoordW-1:0] b);
    return $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
  endfunction

  function automatic logic [SumW-1:0] mag(logic signed [DiffW-1:0] v);
    logic signed [DiffW-1:0] n;
    n = -v;
    return v[DiffW-1] ? SumW'(n[CoordW-1:0]) : SumW'(v[CoordW-1:0]);
  endfunction

  assign desc          = cross_desc(cross_q);
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 3){1'b0}}, verdict_q, (verdict_q == VerdictOk)};

  assign tol    = sum_q >> tol_shift_q;
  assign tol_s  = $signed({{(AccW - SumW){1'b0}}, tol});
  assign hit    = (acc_q <= tol_s) && (acc_q >= -tol_s);
  assign acc_nz = |acc_q;

  assign ax_d = sub33(pick_x(rd0_q, desc.dst), pick_x(base_q, desc.dst));
  assign ay_d = sub33(pick_y(rd0_q, desc.dst), pick_y(base_q, desc.dst));
  assign bx_d = sub33(pick_x(rd1_q, desc.dst), pick_x(base_q, desc.dst));
  assign by_d = sub33(pick_y(rd1_q, desc.dst), pick_y(base_q, desc.dst));

  assign mul_a = (state_q == StMul1) ? ax_q : ay_q;
  assign mul_b = (state_q == StMul1) ? by_q : bx_q;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    raddr0 = desc.base;
    raddr1 = desc.pb;
    if (state_q == StPts) begin
      raddr0 = desc.pa;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[s_axis_tuser] <= s_axis_tdata;
    end
    rd0_q <= mem_q[raddr0];
    rd1_q <= mem_q[raddr1];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StPts: begin
        base_q <= rd0_q;
      end
      StDiff: begin
        ax_q <= ax_d;
        ay_q <= ay_d;
        bx_q <= bx_d;
        by_q <= by_d;
      end
      StMul1: begin
        prod_q <= mul_p;
        sum_q  <= mag(ax_q) + mag(ay_q) + mag(bx_q) + mag(by_q);
      end
      StMul2: begin
        acc_q  <= $signed({prod_q[ProdW-1], prod_q});
        prod_q <= mul_p;
      end
      StAcc: begin
        acc_q <= acc_q - $signed({prod_q[ProdW-1], prod_q});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cross_q     <= '0;
      tol_shift_q <= TolShiftReset;
      src_col_q   <= 1'b0;
      dst_col_q   <= 1'b0;
      src_nz_q    <= 1'b0;
      src_neg_q   <= 1'b0;
      neg_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      verdict_q   <= VerdictOk;
    end else begin
      state_q     <= state_d;
      cross_q     <= cross_d;
      src_col_q   <= src_col_d;
      dst_col_q   <= dst_col_d;
      src_nz_q    <= src_nz_d;
      src_neg_q   <= src_neg_d;
      neg_cnt_q   <= neg_cnt_d;
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
      if (cfg_we_i) begin
        tol_shift_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cross_d     = cross_q;
    src_col_d   = src_col_q;
    dst_col_d   = dst_col_q;
    src_nz_d    = src_nz_q;
    src_neg_d   = src_neg_q;
    neg_cnt_d   = neg_cnt_q;
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc && (s_axis_tuser == LastPoint)) begin
          state_d   = StBase;
          cross_d   = '0;
          src_col_d = 1'b0;
          dst_col_d = 1'b0;
          neg_cnt_d = '0;
        end
      end
      StBase: state_d = StPts;
      StPts:  state_d = StDiff;
      StDiff: state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StAcc;
      StAcc:  state_d = StEval;
      StEval: begin
        if (!desc.orient) begin
          if (hit && !desc.dst) begin
            src_col_d = 1'b1;
          end
          if (hit && desc.dst) begin
            dst_col_d = 1'b1;
          end
        end else if (!desc.dst) begin
          src_nz_d  = acc_nz;
          src_neg_d = acc_q[AccW-1];
        end else if (src_nz_q && acc_nz && (src_neg_q != acc_q[AccW-1])) begin
          neg_cnt_d = neg_cnt_q + NegW'(1);
        end
        if (cross_q == LastCross) begin
          state_d = StDone;
        end else begin
          cross_d = cross_q + CrossW'(1);
          state_d = StBase;
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (src_col_q) begin
            verdict_d = VerdictSrcCol;
          end else if (dst_col_q) begin
            verdict_d = VerdictDstCol;
          end else if ((neg_cnt_q != '0) && (neg_cnt_q != NegW'(4))) begin
            verdict_d = VerdictOrient;
          end else begin
            verdict_d = VerdictOk;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  a_last_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == LastPoint)) |=> !s_axis_tready)
    else $error("input still ready after last point");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == StDone))
    else $error("result raised outside of done state");

  a_cross_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (cross_q <= LastCross))
    else $error("cross counter out of range");

  a_neg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> (neg_cnt_q <= NegW'(4)))
    else $error("orientation mismatch count out of range");

endmodule
`default_nettype wire
